### sv/spil_pkg.sv
package spil_pkg;

    // Pedal full-scale value and lap counter ceiling
    localparam int PEDAL_MAX = 4095;
    localparam int LAP_LIMIT = 999;

    localparam int PEDAL_W   = 12;
    localparam int PERCENT_W = 7;
    localparam int LAPS_W    = 10;
    localparam int LEVELS_W  = 8;

    // Rounded percentage: floor((200*p + PEDAL_MAX) / (2*PEDAL_MAX)),
    // which equals floor((100*p + (PEDAL_MAX-1)/2) / PEDAL_MAX) for odd PEDAL_MAX.
    // The divide by PEDAL_MAX is a multiply by ceil(2^31 / 4095) and a shift,
    // exact for all numerators below 2^19.
    localparam int PCT_NUM_W   = 19;
    localparam int PCT_RECIP_W = 20;
    localparam int PCT_SHIFT   = 31;
    localparam int PCT_PROD_W  = PCT_NUM_W + PCT_RECIP_W;
    localparam int PCT_Q_W     = PCT_PROD_W - PCT_SHIFT;
    localparam logic [PCT_RECIP_W-1:0] PCT_RECIP = 20'd524417;
    localparam int PCT_BIAS    = (PEDAL_MAX - 1) / 2;
    localparam int PCT_FULL    = 100;

    // Bit positions of the button levels in the edge detector word
    localparam int LVL_HEADLIGHT = 0;
    localparam int LVL_LEFT      = 1;
    localparam int LVL_RIGHT     = 2;
    localparam int LVL_DIRECTION = 3;
    localparam int LVL_HAZARD    = 4;
    localparam int LVL_MODE      = 5;
    localparam int LVL_LAP_UP    = 6;
    localparam int LVL_LAP_DOWN  = 7;

    typedef struct packed {
        logic                regen_button;
        logic [PEDAL_W-1:0]  pedal_level;
        logic                headlight_button;
        logic                left_button;
        logic                right_button;
        logic                direction_button;
        logic                horn_button;
        logic                hazard_button;
        logic                mode_button;
        logic                lap_up_button;
        logic                lap_down_button;
    } sample_t;

    typedef struct packed {
        logic [PERCENT_W-1:0] regen_percent;
        logic [PEDAL_W-1:0]   throttle_level;
        logic                 headlight_on;
        logic                 direction_forward;
        logic                 horn_on;
        logic                 hazard_on;
        logic                 left_on;
        logic                 right_on;
        logic                 drive_mode_out;
        logic [LAPS_W-1:0]    laps;
    } result_t;

    // Latch state carried from the latch unit to the result register
    typedef struct packed {
        logic              headlight;
        logic              direction;
        logic              hazard;
        logic              left;
        logic              right;
        logic              mode;
        logic [LAPS_W-1:0] laps;
    } latch_state_t;

endpackage

### sv/steering_panel_input_latch_unit.sv
// Steering panel input latch.
// The sample channel takes one panel sample per beat: calibrated pedal level
// and the button levels. The result channel returns one result per sample:
// regen percentage or throttle, the latched headlight, direction, hazard,
// blinker and drive-mode bits, the live horn level and the lap count.
// A beat moves when valid is high and stall is low on that channel.
// A sample beat is taken into the sample register; when the result register
// is free, the latch update and pedal scaling load the result register, whose
// valid then rises. Throughput is one sample per cycle while the result side
// does not stall; the single reciprocal multiply sits between the two registers.
// When the result side stalls, the result register holds and the sample
// register can still take one more beat; a further sample is stalled until
// the result moves.
// Reset empties both registers, sets direction to forward and clears all other
// latches and the lap count. The first sample after reset only seeds the edge
// detectors; its result still carries the pedal and horn values.
module steering_panel_input_latch_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  spil_pkg::sample_t sample,
    output logic              result_valid,
    input  logic              result_stall,
    output spil_pkg::result_t result
);

    spil_pkg::sample_t             sample_reg;
    logic                          sample_valid_reg;
    logic                          sample_valid_next;
    spil_pkg::result_t             result_reg;
    spil_pkg::result_t             result_next;
    logic                          result_valid_reg;
    logic                          result_valid_next;
    logic                          advance;
    logic                          accept;
    logic [spil_pkg::LEVELS_W-1:0] levels;
    spil_pkg::latch_state_t        latch_next;
    logic [spil_pkg::PERCENT_W-1:0] percent;
    logic [spil_pkg::PEDAL_W-1:0]  throttle;

    // Move a sample into the result register when that register is free
    assign advance      = sample_valid_reg && (!result_valid_reg || !result_stall);
    assign sample_stall = sample_valid_reg && !advance;
    assign accept       = sample_valid && !sample_stall;

    always_comb
    begin
        sample_valid_next = sample_valid_reg;
        if (accept)
            sample_valid_next = 1'b1;
        else if (advance)
            sample_valid_next = 1'b0;

        result_valid_next = result_valid_reg;
        if (advance)
            result_valid_next = 1'b1;
        else if (!result_stall)
            result_valid_next = 1'b0;
    end

    // Pack button levels for the edge detectors
    always_comb
    begin
        levels = '0;
        levels[spil_pkg::LVL_HEADLIGHT] = sample_reg.headlight_button;
        levels[spil_pkg::LVL_LEFT]      = sample_reg.left_button;
        levels[spil_pkg::LVL_RIGHT]     = sample_reg.right_button;
        levels[spil_pkg::LVL_DIRECTION] = sample_reg.direction_button;
        levels[spil_pkg::LVL_HAZARD]    = sample_reg.hazard_button;
        levels[spil_pkg::LVL_MODE]      = sample_reg.mode_button;
        levels[spil_pkg::LVL_LAP_UP]    = sample_reg.lap_up_button;
        levels[spil_pkg::LVL_LAP_DOWN]  = sample_reg.lap_down_button;
    end

    spil_latch u_latch (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .levels     (levels),
        .state_next (latch_next)
    );

    spil_scale u_scale (
        .regen    (sample_reg.regen_button),
        .pedal    (sample_reg.pedal_level),
        .percent  (percent),
        .throttle (throttle)
    );

    // Assemble the result beat
    always_comb
    begin
        result_next.regen_percent     = percent;
        result_next.throttle_level    = throttle;
        result_next.headlight_on      = latch_next.headlight;
        result_next.direction_forward = latch_next.direction;
        result_next.horn_on           = sample_reg.horn_button;
        result_next.hazard_on         = latch_next.hazard;
        result_next.left_on           = latch_next.left;
        result_next.right_on          = latch_next.right;
        result_next.drive_mode_out    = latch_next.mode;
        result_next.laps              = latch_next.laps;
    end

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid_reg <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            sample_valid_reg <= sample_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
            sample_reg <= sample;
        if (advance)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Percentage stays within full scale
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.regen_percent <= spil_pkg::PERCENT_W'(spil_pkg::PCT_FULL)))
        else $error("regen percentage above full scale");

    // Regen and throttle are never both active
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.regen_percent != '0) |-> (result.throttle_level == '0))
        else $error("throttle active during regen");

    // A sample is never dropped: a held sample with a stalled result stalls the input
    assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid_reg && result_valid_reg && result_stall) |-> sample_stall)
        else $error("sample register overrun");

endmodule

### sv/spil_scale.sv
module spil_scale (
    input  logic                          regen,
    input  logic [spil_pkg::PEDAL_W-1:0]  pedal,
    output logic [spil_pkg::PERCENT_W-1:0] percent,
    output logic [spil_pkg::PEDAL_W-1:0]  throttle
);

    logic [spil_pkg::PEDAL_W-1:0]    pedal_clamped;
    logic [spil_pkg::PCT_NUM_W-1:0]  pct_num;
    logic [spil_pkg::PCT_PROD_W-1:0] pct_prod;
    logic [spil_pkg::PCT_Q_W-1:0]    pct_q;

    // Clamp the pedal to its full scale
    always_comb
    begin
        if (spil_pkg::PEDAL_W'(spil_pkg::PEDAL_MAX) < pedal)
            pedal_clamped = spil_pkg::PEDAL_W'(spil_pkg::PEDAL_MAX);
        else
            pedal_clamped = pedal;
    end

    // Scale to a rounded percentage by reciprocal multiply
    assign pct_num  = spil_pkg::PCT_NUM_W'(pedal_clamped) * spil_pkg::PCT_NUM_W'(spil_pkg::PCT_FULL)
                    + spil_pkg::PCT_NUM_W'(spil_pkg::PCT_BIAS);
    assign pct_prod = spil_pkg::PCT_PROD_W'(pct_num) * spil_pkg::PCT_PROD_W'(spil_pkg::PCT_RECIP);
    assign pct_q    = pct_prod[spil_pkg::PCT_PROD_W-1:spil_pkg::PCT_SHIFT];

    // Route the pedal to regen or throttle
    always_comb
    begin
        percent  = '0;
        throttle = '0;
        if (regen)
        begin
            if (pct_q > spil_pkg::PCT_Q_W'(spil_pkg::PCT_FULL))
                percent = spil_pkg::PERCENT_W'(spil_pkg::PCT_FULL);
            else
                percent = pct_q[spil_pkg::PERCENT_W-1:0];
        end
        else
        begin
            throttle = pedal_clamped;
        end
    end

endmodule

### sv/spil_latch.sv
module spil_latch (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           advance,
    input  logic [spil_pkg::LEVELS_W-1:0]  levels,
    output spil_pkg::latch_state_t         state_next
);

    spil_pkg::latch_state_t          state_reg;
    logic [spil_pkg::LEVELS_W-1:0]   prev_reg;
    logic                            primed_reg;
    logic [spil_pkg::LEVELS_W-1:0]   rise;
    logic                            hazard_tog;
    logic [spil_pkg::LAPS_W-1:0]     laps_up;

    assign rise = levels & ~prev_reg;

    // Toggle latches on rising edges once the detectors are seeded
    always_comb
    begin
        state_next = state_reg;
        hazard_tog = state_reg.hazard ^ rise[spil_pkg::LVL_HAZARD];
        laps_up    = state_reg.laps;
        if (primed_reg)
        begin
            state_next.headlight = state_reg.headlight ^ rise[spil_pkg::LVL_HEADLIGHT];
            state_next.direction = state_reg.direction ^ rise[spil_pkg::LVL_DIRECTION];
            state_next.hazard    = hazard_tog;
            // hazard turning on drops both blinkers
            if (hazard_tog && !state_reg.hazard)
            begin
                state_next.left  = 1'b0;
                state_next.right = 1'b0;
            end
            if (!hazard_tog)
            begin
                state_next.left  = state_reg.left ^ rise[spil_pkg::LVL_LEFT];
                state_next.right = state_reg.right ^ rise[spil_pkg::LVL_RIGHT];
            end
            state_next.mode = state_reg.mode ^ rise[spil_pkg::LVL_MODE];
            // step up first, then down, both saturating
            if (rise[spil_pkg::LVL_LAP_UP]
                && state_reg.laps < spil_pkg::LAPS_W'(spil_pkg::LAP_LIMIT))
                laps_up = state_reg.laps + spil_pkg::LAPS_W'(1);
            state_next.laps = laps_up;
            if (rise[spil_pkg::LVL_LAP_DOWN] && laps_up != '0)
                state_next.laps = laps_up - spil_pkg::LAPS_W'(1);
        end
    end

    // Hold latch state; advance once per beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.headlight <= 1'b0;
            state_reg.direction <= 1'b1;
            state_reg.hazard    <= 1'b0;
            state_reg.left      <= 1'b0;
            state_reg.right     <= 1'b0;
            state_reg.mode      <= 1'b0;
            state_reg.laps      <= '0;
            prev_reg            <= '0;
            primed_reg          <= 1'b0;
        end
        else if (advance)
        begin
            state_reg  <= state_next;
            prev_reg   <= levels;
            primed_reg <= 1'b1;
        end
    end

    // Hazards on keep both blinkers off
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.hazard |-> (!state_reg.left && !state_reg.right))
        else $error("blinker latched while hazards on");

    // Lap count never passes its ceiling
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.laps <= spil_pkg::LAPS_W'(spil_pkg::LAP_LIMIT))
        else $error("lap count above limit");

    // The first beat after reset changes no latch
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !primed_reg) |=> (state_reg == $past(state_reg)))
        else $error("latch changed on seeding beat");

endmodule

### sim/steering_panel_input_latch_unit_test.sv
`timescale 1ns / 1ps

module steering_panel_input_latch_unit_test;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_WAIT = 4;
    localparam int PRINT_CAP = 100;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              sample_valid = 1'b0;
    logic              sample_stall;
    spil_pkg::sample_t sample = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    spil_pkg::result_t result;

    // Panel latch state as the block should hold it
    logic                          st_headlight = 1'b0;
    logic                          st_direction = 1'b1;
    logic                          st_hazard = 1'b0;
    logic                          st_left = 1'b0;
    logic                          st_right = 1'b0;
    logic                          st_mode = 1'b0;
    int                            lap_tally = 0;
    logic [spil_pkg::LEVELS_W-1:0] prev_levels = '0;
    logic                          primed = 1'b0;

    spil_pkg::result_t pending_results[$];
    spil_pkg::result_t want;
    bit      idle_on = 1'b1;
    int      stall_left = 0;
    int      errors = 0;
    int      samples_sent = 0;
    int      results_seen = 0;
    int      lap_peak = 0;
    int      hazard_rises = 0;
    int      cycles = 0;

    steering_panel_input_latch_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #2 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Run hung after %0d cycles, %0d results outstanding",
                     cycles, pending_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic report_error(input string msg);
        if (errors < PRINT_CAP)
            $display("ERROR at %0t: %s", $realtime, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input int got, input int exp_val);
        if (got != exp_val)
            report_error($sformatf("result %0d field %s: got %0d, want %0d",
                                   results_seen, name, got, exp_val));
    endtask

    // Advance the latch state by one panel sample and build its result
    function automatic spil_pkg::result_t latch_panel(input spil_pkg::sample_t s);
        spil_pkg::result_t             r;
        logic [spil_pkg::LEVELS_W-1:0] lv;
        logic [spil_pkg::LEVELS_W-1:0] rise;
        int                            ped;
        int                            pct;
        logic                          was_hazard;
        lv = '0;
        lv[spil_pkg::LVL_HEADLIGHT] = s.headlight_button;
        lv[spil_pkg::LVL_LEFT]      = s.left_button;
        lv[spil_pkg::LVL_RIGHT]     = s.right_button;
        lv[spil_pkg::LVL_DIRECTION] = s.direction_button;
        lv[spil_pkg::LVL_HAZARD]    = s.hazard_button;
        lv[spil_pkg::LVL_MODE]      = s.mode_button;
        lv[spil_pkg::LVL_LAP_UP]    = s.lap_up_button;
        lv[spil_pkg::LVL_LAP_DOWN]  = s.lap_down_button;
        rise = lv & ~prev_levels;
        r = '0;

        // Regen takes the pedal as a rounded percentage, else throttle follows it
        ped = int'(s.pedal_level);
        if (ped > spil_pkg::PEDAL_MAX)
            ped = spil_pkg::PEDAL_MAX;
        if (s.regen_button)
        begin
            pct = (200 * ped + spil_pkg::PEDAL_MAX) / (2 * spil_pkg::PEDAL_MAX);
            if (pct > spil_pkg::PCT_FULL)
                pct = spil_pkg::PCT_FULL;
            r.regen_percent = spil_pkg::PERCENT_W'(pct);
        end
        else
            r.throttle_level = spil_pkg::PEDAL_W'(ped);

        // Toggle latches on rising edges once the edge detectors are seeded
        if (primed)
        begin
            was_hazard = st_hazard;
            st_headlight ^= rise[spil_pkg::LVL_HEADLIGHT];
            st_direction ^= rise[spil_pkg::LVL_DIRECTION];
            st_hazard ^= rise[spil_pkg::LVL_HAZARD];
            if (st_hazard && !was_hazard)
            begin
                st_left = 1'b0;
                st_right = 1'b0;
                hazard_rises++;
            end
            if (!st_hazard)
            begin
                st_left ^= rise[spil_pkg::LVL_LEFT];
                st_right ^= rise[spil_pkg::LVL_RIGHT];
            end
            st_mode ^= rise[spil_pkg::LVL_MODE];
            if (rise[spil_pkg::LVL_LAP_UP] && lap_tally < spil_pkg::LAP_LIMIT)
                lap_tally++;
            if (rise[spil_pkg::LVL_LAP_DOWN] && lap_tally > 0)
                lap_tally--;
        end
        prev_levels = lv;
        primed = 1'b1;
        if (lap_tally > lap_peak)
            lap_peak = lap_tally;

        r.headlight_on = st_headlight;
        r.direction_forward = st_direction;
        r.horn_on = s.horn_button;
        r.hazard_on = st_hazard;
        r.left_on = st_left;
        r.right_on = st_right;
        r.drive_mode_out = st_mode;
        r.laps = spil_pkg::LAPS_W'(lap_tally);
        return r;
    endfunction

    function automatic spil_pkg::sample_t make_sample(input bit regen,
                                                      input bit [spil_pkg::PEDAL_W-1:0] pedal,
                                                      input bit [spil_pkg::LEVELS_W-1:0] lv,
                                                      input bit horn);
        spil_pkg::sample_t s;
        s.regen_button     = regen;
        s.pedal_level      = pedal;
        s.headlight_button = lv[spil_pkg::LVL_HEADLIGHT];
        s.left_button      = lv[spil_pkg::LVL_LEFT];
        s.right_button     = lv[spil_pkg::LVL_RIGHT];
        s.direction_button = lv[spil_pkg::LVL_DIRECTION];
        s.horn_button      = horn;
        s.hazard_button    = lv[spil_pkg::LVL_HAZARD];
        s.mode_button      = lv[spil_pkg::LVL_MODE];
        s.lap_up_button    = lv[spil_pkg::LVL_LAP_UP];
        s.lap_down_button  = lv[spil_pkg::LVL_LAP_DOWN];
        return s;
    endfunction

    // Offer one sample beat, after a random gap when idling is on, and hold it until accepted
    task automatic send_sample(input spil_pkg::sample_t s);
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap != 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample <= s;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        pending_results.push_back(latch_panel(s));
        samples_sent++;
    endtask

    // Check each result beat against the oldest expectation, then draw a stall
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
                report_error("result beat with no sample outstanding");
            else
            begin
                want = pending_results.pop_front();
                check_field("regen_percent", int'(result.regen_percent),
                            int'(want.regen_percent));
                check_field("throttle_level", int'(result.throttle_level),
                            int'(want.throttle_level));
                check_field("headlight_on", int'(result.headlight_on),
                            int'(want.headlight_on));
                check_field("direction_forward", int'(result.direction_forward),
                            int'(want.direction_forward));
                check_field("horn_on", int'(result.horn_on), int'(want.horn_on));
                check_field("hazard_on", int'(result.hazard_on), int'(want.hazard_on));
                check_field("left_on", int'(result.left_on), int'(want.left_on));
                check_field("right_on", int'(result.right_on), int'(want.right_on));
                check_field("drive_mode_out", int'(result.drive_mode_out),
                            int'(want.drive_mode_out));
                check_field("laps", int'(result.laps), int'(want.laps));
            end
            results_seen++;
            stall_left = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
        end
        else if (stall_left != 0)
            stall_left--;
        result_stall <= (stall_left != 0);
    end

    // First sample after reset only seeds the edge detectors
    task automatic test_first_sample;
        send_sample(make_sample(1'b1, spil_pkg::PEDAL_W'(spil_pkg::PEDAL_MAX), '1, 1'b1));
        send_sample(make_sample(1'b0, '0, '0, 1'b0));
    endtask

    // Pedal extremes and rounding either side of one percent
    task automatic test_pedal_scaling;
        send_sample(make_sample(1'b0, 12'd4095, '0, 1'b1));
        send_sample(make_sample(1'b1, 12'd0, '0, 1'b0));
        send_sample(make_sample(1'b1, 12'd20, '0, 1'b1));
        send_sample(make_sample(1'b1, 12'd21, '0, 1'b0));
        send_sample(make_sample(1'b1, 12'd2047, '0, 1'b1));
        send_sample(make_sample(1'b1, 12'd4094, '0, 1'b0));
        send_sample(make_sample(1'b0, 12'd1, '0, 1'b0));
    endtask

    task automatic test_latch_toggles;
        bit [spil_pkg::LEVELS_W-1:0] lv;
        lv = '0;
        lv[spil_pkg::LVL_HEADLIGHT] = 1'b1;
        lv[spil_pkg::LVL_DIRECTION] = 1'b1;
        lv[spil_pkg::LVL_MODE] = 1'b1;
        send_sample(make_sample(1'b0, 12'd100, lv, 1'b0));
        send_sample(make_sample(1'b0, 12'd100, '0, 1'b0));
    endtask

    // Hazard rise clears blinkers, blinkers ignored while on, live again on release
    task automatic test_hazard_blinkers;
        bit [spil_pkg::LEVELS_W-1:0] left_lv;
        bit [spil_pkg::LEVELS_W-1:0] haz_lv;
        bit [spil_pkg::LEVELS_W-1:0] both_lv;
        bit [spil_pkg::LEVELS_W-1:0] haz_right_lv;
        left_lv = '0;
        left_lv[spil_pkg::LVL_LEFT] = 1'b1;
        haz_lv = '0;
        haz_lv[spil_pkg::LVL_HAZARD] = 1'b1;
        both_lv = left_lv;
        both_lv[spil_pkg::LVL_RIGHT] = 1'b1;
        haz_right_lv = haz_lv;
        haz_right_lv[spil_pkg::LVL_RIGHT] = 1'b1;
        send_sample(make_sample(1'b0, 12'd0, left_lv, 1'b0));
        send_sample(make_sample(1'b0, 12'd0, '0, 1'b0));
        send_sample(make_sample(1'b0, 12'd0, haz_lv, 1'b0));
        send_sample(make_sample(1'b0, 12'd0, '0, 1'b0));
        send_sample(make_sample(1'b0, 12'd0, both_lv, 1'b0));
        send_sample(make_sample(1'b0, 12'd0, '0, 1'b0));
        send_sample(make_sample(1'b0, 12'd0, haz_right_lv, 1'b0));
        send_sample(make_sample(1'b0, 12'd0, '0, 1'b0));
    endtask

    // Floor at zero, one step up, both buttons rising together
    task automatic test_lap_counter;
        bit [spil_pkg::LEVELS_W-1:0] up_lv;
        bit [spil_pkg::LEVELS_W-1:0] down_lv;
        up_lv = '0;
        up_lv[spil_pkg::LVL_LAP_UP] = 1'b1;
        down_lv = '0;
        down_lv[spil_pkg::LVL_LAP_DOWN] = 1'b1;
        send_sample(make_sample(1'b0, 12'd0, down_lv, 1'b0));
        send_sample(make_sample(1'b0, 12'd0, '0, 1'b0));
        send_sample(make_sample(1'b0, 12'd0, up_lv, 1'b0));
        send_sample(make_sample(1'b0, 12'd0, '0, 1'b0));
        send_sample(make_sample(1'b0, 12'd0, up_lv | down_lv, 1'b0));
        send_sample(make_sample(1'b0, 12'd0, '0, 1'b0));
    endtask

    function automatic spil_pkg::sample_t random_sample;
        spil_pkg::sample_t s;
        s = spil_pkg::sample_t'($urandom);
        case ($urandom_range(0, 7))
            0: s.pedal_level = '0;
            1: s.pedal_level = spil_pkg::PEDAL_W'(spil_pkg::PEDAL_MAX);
            default: s.pedal_level =
                spil_pkg::PEDAL_W'($urandom_range(0, spil_pkg::PEDAL_MAX));
        endcase
        return s;
    endfunction

    // Random panel noise, idling on and off in blocks
    task automatic test_random_panel(input int count);
        for (int i = 0; i < count; i++)
        begin
            idle_on = ((i >> 6) & 1) == 0;
            send_sample(random_sample());
        end
    endtask

    // Pulse lap up every other sample until the counter has sat at its ceiling for 40 samples
    task automatic test_lap_ceiling;
        spil_pkg::sample_t s;
        int      i;
        int      dwell;
        i = 0;
        dwell = 0;
        while (dwell < 40)
        begin
            idle_on = ((i >> 7) & 1) == 1;
            s = random_sample();
            s.lap_up_button = i[0];
            s.lap_down_button = ($urandom_range(0, 255) == 0);
            send_sample(s);
            if (lap_tally == spil_pkg::LAP_LIMIT)
                dwell++;
            i++;
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_first_sample();
        test_pedal_scaling();
        test_latch_toggles();
        test_hazard_blinkers();
        test_lap_counter();
        test_random_panel(100);
        test_lap_ceiling();
        test_random_panel(50);

        // Drain the pipeline
        sample_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d panel samples, checked %0d results, %0d errors.",
                 samples_sent, results_seen, errors);
        $display("Lap count peaked at %0d; hazards switched on %0d times.",
                 lap_peak, hazard_rises);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### steering_panel_input_latch_unit.f
sv/spil_pkg.sv
sv/spil_scale.sv
sv/spil_latch.sv
sv/steering_panel_input_latch_unit.sv
sim/steering_panel_input_latch_unit_test.sv
